### rtl/fourier_harmonic_projection_top_macros.svh
// Assertion macros used by the RTL sequencer module fhp_seq.
`ifndef FOURIER_HARMONIC_PROJECTION_TOP_MACROS_SVH
`define FOURIER_HARMONIC_PROJECTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FHP_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("implication check failed");
`define FHP_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define FHP_ASSERT_IMP(lbl, clk, rstn, a, b)
`define FHP_ASSERT_NXT(lbl, clk, rstn, a, b)
`endif
`endif

### rtl/fhp_pkg.sv
// Types, constants and sequencer states of the harmonic projection block.
package fhp_pkg;

    localparam int MAX_COEFFS_DEF = 32;
    localparam int CFG_W          = 6;
    localparam int ACC_W          = 48;
    localparam int MUL_W          = 34;
    localparam int PROD_W         = 2 * MUL_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd16;

    localparam logic signed [MUL_W-1:0] Q30_ONE   = 34'sd1073741824;
    localparam logic signed [MUL_W-1:0] SQRT2_Q30 = 34'sd1518500250;
    localparam logic signed [MUL_W-1:0] SIN_A1    = 34'sd1686629713;
    localparam logic signed [MUL_W-1:0] SIN_A3    = 34'sd693598668;
    localparam logic signed [MUL_W-1:0] SIN_A5    = 34'sd85569306;
    localparam logic signed [MUL_W-1:0] SIN_A7    = 34'sd5026995;
    localparam logic signed [MUL_W-1:0] SIN_A9    = 34'sd172272;

    typedef struct packed {
        logic signed [31:0] sample;
        logic [15:0]        angle;
        logic [17:0]        weight;
        logic               last;
    } fhp_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] coefficient;
        logic [4:0]              coeff_index;
        logic                    final_res;
    } fhp_out_t;

    typedef struct packed {
        logic                    shift;
        logic signed [ACC_W-1:0] d;
    } fhp_ring_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_CSAVE,
        ST_KSTART,
        ST_X2,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_SX,
        ST_SQ,
        ST_LO,
        ST_HI,
        ST_ADD,
        ST_EMIT
    } fhp_state_t;

endpackage

### rtl/fhp_cell.sv
// One accumulator cell of the rotating coefficient ring.
module fhp_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fhp_pkg::fhp_ring_t              ctl,
    input  logic signed [fhp_pkg::ACC_W-1:0] d_in,
    output logic signed [fhp_pkg::ACC_W-1:0] q
);
    import fhp_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.shift)
        begin
            acc_next = d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign q = acc_reg;

endmodule

### rtl/fhp_seq.sv
// Sequencer and shared-multiplier datapath for basis evaluation and accumulation.
module fhp_seq #(
    parameter int MAX_COEFFS = fhp_pkg::MAX_COEFFS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  fhp_pkg::fhp_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output fhp_pkg::fhp_out_t                out_data,
    input  logic                             cfg_wr_en,
    input  logic [fhp_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic signed [fhp_pkg::ACC_W-1:0] head,
    output fhp_pkg::fhp_ring_t               ring
);
    import fhp_pkg::*;
    `include "fourier_harmonic_projection_top_macros.svh"

    localparam int KW = $clog2(MAX_COEFFS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(MAX_COEFFS - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI = 68'sh0_0000_7FFF_FFFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - 68'sd1;

    fhp_state_t state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [CFG_W-1:0] cfg_reg, cfg_next;
    fhp_in_t item_reg, item_next;
    logic signed [50:0] c_reg, c_next;
    logic [15:0] phase_reg, phase_next;
    logic [1:0] quad_reg, quad_next;
    logic signed [MUL_W-1:0] x_reg, x_next;
    logic signed [MUL_W-1:0] x2_reg, x2_next;
    logic signed [MUL_W-1:0] basis_reg, basis_next;
    logic signed [MUL_W-1:0] lo_reg, lo_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic out_valid_reg, out_valid_next;
    fhp_out_t out_data_reg, out_data_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [KW-1:0] n_eff;
    logic k_active, can_load, out_load, in_xfer;
    logic [15:0] ph_now, ph_eff;
    logic [14:0] r_val;
    logic signed [PROD_W-1:0] p30, term, total;
    logic signed [MUL_W-1:0] s_val;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = KW'(1);
        end
        else if ({1'b0, cfg_reg} > 7'(MAX_COEFFS))
        begin
            n_eff = KW'(MAX_COEFFS);
        end
        else
        begin
            n_eff = KW'(cfg_reg);
        end
    end

    assign k_active = k_reg < n_eff;
    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign in_xfer  = in_valid && !in_stall;
    assign p30      = prod_reg >>> 30;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_PROD;
            ST_PROD:   state_next = ST_CSAVE;
            ST_CSAVE:  state_next = ST_KSTART;
            ST_KSTART:
            begin
                if (!k_active)
                begin
                    if (k_reg == K_LAST)
                        state_next = item_reg.last ? ST_EMIT : ST_IDLE;
                end
                else if (k_reg == '0)
                    state_next = ST_LO;
                else
                    state_next = ST_X2;
            end
            ST_X2:     state_next = ST_H1;
            ST_H1:     state_next = ST_H2;
            ST_H2:     state_next = ST_H3;
            ST_H3:     state_next = ST_H4;
            ST_H4:     state_next = ST_SX;
            ST_SX:     state_next = ST_SQ;
            ST_SQ:     state_next = ST_LO;
            ST_LO:     state_next = ST_HI;
            ST_HI:     state_next = ST_ADD;
            ST_ADD:
            begin
                if (k_reg == K_LAST)
                    state_next = item_reg.last ? ST_EMIT : ST_IDLE;
                else
                    state_next = ST_KSTART;
            end
            ST_EMIT:
            begin
                if (k_reg == K_LAST && (!k_active || can_load))
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        k_next         = k_reg;
        cfg_next       = cfg_wr_en ? cfg_wr_data : cfg_reg;
        item_next      = item_reg;
        c_next         = c_reg;
        phase_next     = phase_reg;
        quad_next      = quad_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        basis_next     = basis_reg;
        lo_next        = lo_reg;
        mul_a          = '0;
        mul_b          = '0;
        ring.shift     = 1'b0;
        ring.d         = head;
        out_load       = 1'b0;
        out_data_next  = out_data_reg;
        ph_now         = k_reg[0] ? phase_reg + item_reg.angle : phase_reg;
        ph_eff         = k_reg[0] ? ph_now + 16'd16384 : ph_now;
        r_val          = ph_eff[14] ? 15'd16384 - {1'b0, ph_eff[13:0]}
                                    : {1'b0, ph_eff[13:0]};
        term           = (prod_reg + PROD_W'(lo_reg)) >>> 10;
        total          = PROD_W'(head) + term;
        s_val          = '0;
        if (p30 > PROD_W'(Q30_ONE))
            s_val = Q30_ONE;
        else if (p30 >= 0)
            s_val = MUL_W'(p30);
        if (quad_reg[1])
            s_val = -s_val;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    item_next  = in_data;
                    k_next     = '0;
                    phase_next = '0;
                end
            end
            ST_PROD:
            begin
                mul_a = MUL_W'(item_reg.sample);
                mul_b = MUL_W'($signed({1'b0, item_reg.weight}));
            end
            ST_CSAVE:  c_next = prod_reg[50:0];
            ST_KSTART:
            begin
                if (!k_active)
                begin
                    ring.shift = 1'b1;
                    k_next     = (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
                end
                else if (k_reg == '0)
                    basis_next = Q30_ONE;
                else
                begin
                    phase_next = ph_now;
                    quad_next  = ph_eff[15:14];
                    x_next     = MUL_W'({r_val, 16'b0});
                    mul_a      = x_next;
                    mul_b      = x_next;
                end
            end
            ST_X2:
            begin
                x2_next = MUL_W'(p30);
                mul_a   = SIN_A9;
                mul_b   = x2_next;
            end
            ST_H1:
            begin
                mul_a = MUL_W'(p30) - SIN_A7;
                mul_b = x2_reg;
            end
            ST_H2:
            begin
                mul_a = MUL_W'(p30) + SIN_A5;
                mul_b = x2_reg;
            end
            ST_H3:
            begin
                mul_a = MUL_W'(p30) - SIN_A3;
                mul_b = x2_reg;
            end
            ST_H4:
            begin
                mul_a = MUL_W'(p30) + SIN_A1;
                mul_b = x_reg;
            end
            ST_SX:
            begin
                mul_a = s_val;
                mul_b = SQRT2_Q30;
            end
            ST_SQ:     basis_next = MUL_W'(p30);
            ST_LO:
            begin
                mul_a = MUL_W'($signed({1'b0, c_reg[19:0]}));
                mul_b = basis_reg;
            end
            ST_HI:
            begin
                lo_next = MUL_W'(prod_reg >>> 20);
                mul_a   = MUL_W'(c_reg >>> 20);
                mul_b   = basis_reg;
            end
            ST_ADD:
            begin
                ring.shift = 1'b1;
                if (total > SAT_HI)
                    ring.d = ACC_W'(SAT_HI);
                else if (total < SAT_LO)
                    ring.d = ACC_W'(SAT_LO);
                else
                    ring.d = ACC_W'(total);
                k_next = (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (!k_active || can_load)
                begin
                    ring.shift = 1'b1;
                    ring.d     = '0;
                    k_next     = (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
                    if (k_active)
                    begin
                        out_load                  = 1'b1;
                        out_data_next.coefficient = head;
                        out_data_next.coeff_index = 5'(k_reg);
                        out_data_next.final_res   = (k_reg + 1'b1) == n_eff;
                    end
                end
            end
            default:   k_next = '0;
        endcase

        prod_next      = mul_a * mul_b;
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        c_reg        <= c_next;
        phase_reg    <= phase_next;
        quad_reg     <= quad_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        basis_reg    <= basis_next;
        lo_reg       <= lo_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `FHP_ASSERT_NXT(a_accept_starts, clk, rst_n, in_xfer, state_reg == ST_PROD)
    `FHP_ASSERT_IMP(a_load_in_emit, clk, rst_n, out_load, state_reg == ST_EMIT)
    `FHP_ASSERT_IMP(a_add_active, clk, rst_n, state_reg == ST_ADD, k_active)
    `FHP_ASSERT_IMP(a_hold_on_stall, clk, rst_n, out_valid_reg && out_stall,
                    !out_load)

endmodule

### rtl/fourier_harmonic_projection_top.sv
// Top level of the Fourier harmonic projection block.
// Usage: each input transfer (in_valid high, in_stall low) carries one
// direction: sample, angle, weight and a last flag. in_stall is high while
// an item is being worked on. Per item the sequencer walks a ring of
// MAX_COEFFS accumulator cells: one shared 34x34 multiplier evaluates each
// basis value for the n coefficients in use. On a last item the ring is then
// rotated once more, emitting n coefficient transfers in basis order and
// clearing every cell.
// out_valid comes from an output register; while out_stall is high the
// register holds its result and emission pauses.
// cfg_wr_en/cfg_wr_data write the coefficient count while idle; the user
// must keep to this, as the block itself does not enforce it.
// Reset clears all accumulators, sets the count to 16 and drops out_valid.
module fourier_harmonic_projection_top #(
    parameter int MAX_COEFFS = fhp_pkg::MAX_COEFFS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  fhp_pkg::fhp_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fhp_pkg::fhp_out_t         out_data,
    input  logic                      cfg_wr_en,
    input  logic [fhp_pkg::CFG_W-1:0] cfg_wr_data
);
    import fhp_pkg::*;

    fhp_ring_t ring;
    logic signed [ACC_W-1:0] acc_q [MAX_COEFFS];

    fhp_seq #(
        .MAX_COEFFS(MAX_COEFFS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (acc_q[0]),
        .ring        (ring)
    );

    for (genvar i = 0; i < MAX_COEFFS; i++)
    begin : g_cell
        if (i == MAX_COEFFS - 1)
        begin : g_tail
            fhp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ring),
                .d_in  (ring.d),
                .q     (acc_q[i])
            );
        end
        else
        begin : g_body
            fhp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ring),
                .d_in  (acc_q[i+1]),
                .q     (acc_q[i])
            );
        end
    end

endmodule

### dv/fourier_harmonic_projection_checker.sv
// Checker for the harmonic projection block: predicts coefficients and compares transfers.
module fourier_harmonic_projection_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  fhp_pkg::fhp_in_t          in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  fhp_pkg::fhp_out_t         out_data,
    input  logic                      cfg_wr_en,
    input  logic [fhp_pkg::CFG_W-1:0] cfg_wr_data,
    output int                        fail_count,
    output int                        pending,
    output int                        coeffs_seen,
    output int                        sets_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import fhp_pkg::*;

    localparam int NCOEF = MAX_COEFFS_DEF;

    logic signed [63:0] acc [NCOEF];
    logic [CFG_W-1:0]   count_reg;
    fhp_out_t           coeff_q [$];

    function automatic logic signed [63:0] floor_shift(input logic signed [127:0] v,
                                                       input int s);
        logic signed [127:0] r;
        r = v >>> s;
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return floor_shift(p, 30);
    endfunction

    function automatic logic signed [63:0] quarter_sine(input logic [15:0] phase);
        logic [1:0]         quad;
        logic signed [63:0] r, x, x2, t, s;
        quad = phase[15:14];
        r = 64'(phase[13:0]);
        if (quad[0])
            r = 16384 - r;
        x = r * 65536;
        x2 = qmul(x, x);
        t = 64'sd172272;
        t = qmul(t, x2) - 64'sd5026995;
        t = qmul(t, x2) + 64'sd85569306;
        t = qmul(t, x2) - 64'sd693598668;
        t = qmul(t, x2) + 64'sd1686629713;
        s = qmul(t, x);
        if (s < 0)
            s = 0;
        if (s > 64'sd1073741824)
            s = 64'sd1073741824;
        return quad[1] ? -s : s;
    endfunction

    function automatic logic signed [63:0] harmonic(input int k, input logic [15:0] angle);
        logic [31:0] m;
        logic [15:0] phase;
        if (k == 0)
            return 64'sd1073741824;
        m = (k + 1) >> 1;
        phase = 16'(m * angle);
        if (k % 2 == 1)
            phase = phase + 16'd16384;
        return qmul(quarter_sine(phase), 64'sd1518500250);
    endfunction

    task automatic project_item(input fhp_in_t it);
        logic signed [63:0]  c, sum;
        logic signed [127:0] prod;
        fhp_out_t            o;
        int                  n;
        c = 64'(it.sample) * $signed({46'd0, it.weight});
        n = count_reg;
        if (n == 0)
            n = 1;
        if (n > NCOEF)
            n = NCOEF;
        for (int k = 0; k < n; k++)
        begin
            prod = 128'(c) * 128'(harmonic(k, it.angle));
            sum = acc[k] + floor_shift(prod, 30);
            if (sum > 64'sd140737488355327)
                sum = 64'sd140737488355327;
            if (sum < -64'sd140737488355328)
                sum = -64'sd140737488355328;
            acc[k] = sum;
        end
        if (it.last)
        begin
            for (int k = 0; k < n; k++)
            begin
                o.coefficient = acc[k][47:0];
                o.coeff_index = 5'(k);
                o.final_res = (k + 1 == n);
                coeff_q.push_back(o);
            end
            for (int k = 0; k < NCOEF; k++)
                acc[k] = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: MISMATCH %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fhp_out_t w;
        if (!rst_n)
        begin
            for (int k = 0; k < NCOEF; k++)
                acc[k] = 0;
            count_reg = CFG_RESET;
            coeff_q.delete();
            fail_count = 0;
            coeffs_seen = 0;
            sets_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg = cfg_wr_data;
            if (in_valid && !in_stall)
                project_item(in_data);
            if (out_valid && !out_stall)
            begin
                coeffs_seen++;
                if (coeff_q.size() == 0)
                    report_mismatch("unexpected transfer", 64'(out_data), 0);
                else
                begin
                    w = coeff_q.pop_front();
                    if (out_data.coefficient !== w.coefficient)
                        report_mismatch("coefficient", 64'(out_data.coefficient),
                                        64'(w.coefficient));
                    if (out_data.coeff_index !== w.coeff_index)
                        report_mismatch("coeff_index", 64'(out_data.coeff_index),
                                        64'(w.coeff_index));
                    if (out_data.final_res !== w.final_res)
                        report_mismatch("final_res", 64'(out_data.final_res),
                                        64'(w.final_res));
                    if (w.final_res)
                        sets_seen++;
                end
            end
        end
        pending = coeff_q.size();
    end
endmodule

### dv/fourier_harmonic_projection_top_tb.sv
// Testbench top: drives directions and coefficient counts into the projection block.
module fourier_harmonic_projection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fhp_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    fhp_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    fhp_out_t         out_data;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               fail_count;
    int               pending;
    int               coeffs_seen;
    int               sets_seen;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               hold_off;
    int               items_sent;

    fourier_harmonic_projection_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    fourier_harmonic_projection_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .coeffs_seen (coeffs_seen),
        .sets_seen   (sets_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #300ms;
        $display("Timeout waiting for coefficient transfers");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(input fhp_in_t it);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        items_sent++;
    endtask

    task automatic send_dir(input logic [31:0] s, input logic [15:0] a,
                            input logic [17:0] w, input logic l);
        fhp_in_t it;
        it.sample = s;
        it.angle = a;
        it.weight = w;
        it.last = l;
        send_item(it);
    endtask

    task automatic drain_and_config(input logic [CFG_W-1:0] val);
        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_set(input int len);
        logic [31:0] s;
        logic [17:0] w;
        for (int i = 0; i < len; i++)
        begin
            s = $urandom;
            w = 18'($urandom);
            case ($urandom_range(3))
                0: s = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
                1: s = $signed(16'($urandom)) ;
                default: ;
            endcase
            if ($urandom_range(3) == 0)
                w = $urandom_range(1) ? 18'h3ffff : 18'h10000;
            send_dir(s, 16'($urandom), w, i == len - 1);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] counts [8];
        counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd17, 6'd2, 6'd9};
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed at reset count: extremes, quadrant angles, saturation
        send_dir(32'h7fffffff, 16'h0000, 18'h3ffff, 1'b0);
        send_dir(32'h7fffffff, 16'h4000, 18'h3ffff, 1'b0);
        send_dir(32'h7fffffff, 16'h8000, 18'h3ffff, 1'b0);
        send_dir(32'h7fffffff, 16'hc000, 18'h3ffff, 1'b0);
        send_dir(32'h7fffffff, 16'hffff, 18'h3ffff, 1'b1);
        send_dir(32'h80000000, 16'h2000, 18'h3ffff, 1'b0);
        send_dir(32'h80000000, 16'h6000, 18'h3ffff, 1'b0);
        send_dir(32'h80000000, 16'h0001, 18'h3ffff, 1'b1);
        send_dir(32'h00010000, 16'h1234, 18'h00000, 1'b0);
        send_dir(32'h00000000, 16'h5555, 18'h10000, 1'b0);
        send_dir(32'hffff0000, 16'haaaa, 18'h00001, 1'b1);
        send_dir(32'h00010000, 16'h3fff, 18'h10000, 1'b1);

        // count changed within a set
        drain_and_config(6'd4);
        send_dir(32'h00050000, 16'h1000, 18'h10000, 1'b0);
        drain_and_config(6'd32);
        send_dir(32'h00030000, 16'h7000, 18'h08000, 1'b1);

        // long receiver hold-off with the sender still offering
        drain_and_config(6'd3);
        hold_off = 1;
        fork
            begin
                int n;
                n = 0;
                while (n < 3000)
                begin
                    @(negedge clk);
                    n++;
                end
                hold_off = 0;
            end
            begin
                random_set(2);
                random_set(2);
                random_set(2);
                random_set(3);
            end
        join

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 12 : 0;
            for (int j = 0; j < 8; j++)
            begin
                if (j % 3 == 0)
                    drain_and_config(counts[(ph * 3 + j / 3) % 8]);
                random_set($urandom_range(1, 12));
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        $display("Sent %0d directions; checked %0d coefficients in %0d sets.",
                 items_sent, coeffs_seen, sets_seen);
        $display("Counts covered 0, 1, 2, 3, 4, 5, 9, 16, 17, 32 and 63, plus a long stall.");
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/fhp_pkg.sv
rtl/fhp_cell.sv
rtl/fhp_seq.sv
rtl/fourier_harmonic_projection_top.sv
dv/fourier_harmonic_projection_checker.sv
dv/fourier_harmonic_projection_top_tb.sv
